[sv/fsa_pkg.sv]
// shared constants, types and helpers for the framed slotted aloha node sequencer
package fsa_pkg;

  // air-time figures in radio ticks
  localparam int SLOT_TICKS      = 216;
  localparam int BEACON_TICKS    = 32;
  localparam int DATA_TICKS      = 152;
  localparam int ACK_TICKS       = 32;
  localparam int SHORT_GAP_TICKS = 16;
  localparam int LONG_GAP_TICKS  = 32;

  localparam int BEACON_WAIT_SHIFT = 4;
  localparam int BEACON_RX_MARGIN  = 3;
  localparam int DATA_PREP         = 4;
  localparam int DATA_PROC         = 1;
  localparam int ACK_PREP          = 1;
  localparam int ACK_PROC          = 1;

  // field widths
  localparam int MODE_W  = 4;
  localparam int KIND_W  = 2;
  localparam int SLOT_W  = 8;
  localparam int CHAN_W  = 8;
  localparam int ADDR_W  = 16;
  localparam int RND_W   = 16;
  localparam int TURN_W  = 4;
  localparam int CMD_W   = 2;
  localparam int TICK_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // internal arithmetic widths
  localparam int DLY_W     = 24;
  localparam int PROD_W    = DLY_W - 1;
  localparam int DIV_CNT_W = $clog2(RND_W);

  // event codes
  localparam logic [MODE_W-1:0] MODE_BEACON_LISTEN = 4'd0;
  localparam logic [MODE_W-1:0] MODE_FRAME_START   = 4'd1;
  localparam logic [MODE_W-1:0] MODE_BEACON_END    = 4'd2;
  localparam logic [MODE_W-1:0] MODE_BEACON_WIN    = 4'd3;
  localparam logic [MODE_W-1:0] MODE_DATA_START    = 4'd4;
  localparam logic [MODE_W-1:0] MODE_DATA_END      = 4'd5;
  localparam logic [MODE_W-1:0] MODE_ACK_LISTEN    = 4'd6;
  localparam logic [MODE_W-1:0] MODE_ACK_END       = 4'd7;
  localparam logic [MODE_W-1:0] MODE_ACK_WIN       = 4'd8;

  // radio commands
  localparam logic [CMD_W-1:0] RADIO_NONE = 2'd0;
  localparam logic [CMD_W-1:0] RADIO_RX   = 2'd1;
  localparam logic [CMD_W-1:0] RADIO_TX   = 2'd2;
  localparam logic [CMD_W-1:0] RADIO_STBY = 2'd3;

  // packet kinds
  localparam logic [KIND_W-1:0] KIND_BEACON = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ACK    = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RX_TURN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TX_TURN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PHY_HEADER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNSYNC_LIMIT = 3'd4;

  // reset values
  localparam logic [CHAN_W-1:0] DEFAULT_CHANNEL = 8'd26;
  localparam logic [SLOT_W-1:0] UNSYNC_RESET    = 8'd16;
  localparam logic [TURN_W-1:0] RX_TURN_RESET   = 4'd1;
  localparam logic [TURN_W-1:0] TX_TURN_RESET   = 4'd1;
  localparam logic [TURN_W-1:0] PHY_HDR_RESET   = 4'd2;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic div_step;
    logic mul_load;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_busy;
  } dp_stat_t;

  // two's complement delay clamped into 0..max tick count
  function automatic logic [TICK_W-1:0] clamp_delay(input logic [DLY_W-1:0] v);
    logic [TICK_W-1:0] r;
    if (v[DLY_W-1]) begin
      r = '0;
    end else if (v[DLY_W-2:TICK_W] != '0) begin
      r = '1;
    end else begin
      r = v[TICK_W-1:0];
    end
    return r;
  endfunction

endpackage

[sv/fsa_ctrl.sv]
// sequencing state machine for the node sequencer
module fsa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  fsa_pkg::dp_stat_t  stat,
  output fsa_pkg::dp_cmd_t   cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DEC  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign item_ready = (state == ST_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DEC;
        end
      end
      ST_DEC: begin
        state_next = stat.need_div ? ST_DIV : ST_MUL;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_load = 1'b1;
        state_next   = ST_FIN;
      end
      ST_FIN: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[sv/fsa_dp.sv]
// datapath: config registers, mac state, slot modulo, delay math and result register
module fsa_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  fsa_pkg::dp_cmd_t                   cmd,
  output fsa_pkg::dp_stat_t                  stat,
  input  logic                               cfg_we,
  input  logic [fsa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fsa_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [fsa_pkg::MODE_W-1:0]         mode,
  input  logic                               crc_ok,
  input  logic                               is_protocol_frame,
  input  logic [fsa_pkg::KIND_W-1:0]         packet_kind,
  input  logic [fsa_pkg::SLOT_W-1:0]         slots_in_frame,
  input  logic [fsa_pkg::CHAN_W-1:0]         beacon_channel,
  input  logic                               ack_status_success,
  input  logic [fsa_pkg::ADDR_W-1:0]         destination,
  input  logic [fsa_pkg::RND_W-1:0]          random_value,
  output logic                               result_valid,
  input  logic                               result_ready,
  output logic [fsa_pkg::CMD_W-1:0]          radio_cmd,
  output logic                               timer_start,
  output logic [fsa_pkg::TICK_W-1:0]         delay_ticks,
  output logic [fsa_pkg::MODE_W-1:0]         timer_target,
  output logic                               synchronized,
  output logic                               reset_request,
  output logic [fsa_pkg::SLOT_W-1:0]         chosen_slot,
  output logic                               ack_success,
  output logic [fsa_pkg::CHAN_W-1:0]         channel
);

  localparam int DW = fsa_pkg::DLY_W;

  // configuration
  logic [fsa_pkg::ADDR_W-1:0] own_address;
  logic [fsa_pkg::TURN_W-1:0] rx_turnaround;
  logic [fsa_pkg::TURN_W-1:0] tx_turnaround;
  logic [fsa_pkg::TURN_W-1:0] phy_header_ticks;
  logic [fsa_pkg::SLOT_W-1:0] unsync_limit;

  // mac state
  logic                       beacon_seen;
  logic [fsa_pkg::SLOT_W-1:0] frame_slots;
  logic [fsa_pkg::SLOT_W-1:0] picked_slot;
  logic [fsa_pkg::SLOT_W-1:0] slots_left;
  logic [fsa_pkg::SLOT_W-1:0] sync_budget;
  logic                       in_sync;
  logic                       success_flag;
  logic [fsa_pkg::CHAN_W-1:0] current_channel;

  // captured event
  logic [fsa_pkg::MODE_W-1:0] ev_mode;
  logic                       ev_crc;
  logic                       ev_proto;
  logic [fsa_pkg::KIND_W-1:0] ev_kind;
  logic [fsa_pkg::SLOT_W-1:0] ev_slots;
  logic [fsa_pkg::CHAN_W-1:0] ev_chan;
  logic                       ev_ack;
  logic [fsa_pkg::ADDR_W-1:0] ev_dest;

  // modulo unit
  logic [fsa_pkg::RND_W-1:0]     dvd;
  logic [fsa_pkg::SLOT_W-1:0]    rem;
  logic [fsa_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [fsa_pkg::SLOT_W:0]      rem_shift;
  logic [fsa_pkg::SLOT_W:0]      rem_sub;

  // slot-time product
  logic [fsa_pkg::PROD_W-1:0] prod;
  logic [fsa_pkg::SLOT_W-1:0] mul_op;

  logic sync_ok;

  // next values computed at finish
  logic                        beacon_seen_next;
  logic [fsa_pkg::SLOT_W-1:0]  frame_slots_next;
  logic [fsa_pkg::SLOT_W-1:0]  picked_slot_next;
  logic [fsa_pkg::SLOT_W-1:0]  slots_left_next;
  logic [fsa_pkg::SLOT_W-1:0]  sync_budget_next;
  logic                        in_sync_next;
  logic                        success_flag_next;
  logic [fsa_pkg::CHAN_W-1:0]  current_channel_next;
  logic [fsa_pkg::SLOT_W-1:0]  budget_dec;
  logic [fsa_pkg::CMD_W-1:0]   cmd_r;
  logic                        tstart_r;
  logic [DW-1:0]               dly_raw;
  logic [fsa_pkg::MODE_W-1:0]  target_r;
  logic                        rreq_r;

  assign sync_ok = (ev_mode == fsa_pkg::MODE_BEACON_WIN) && beacon_seen && (frame_slots != '0);

  assign stat.need_div = sync_ok;
  assign stat.div_last = (div_cnt == fsa_pkg::DIV_CNT_W'(fsa_pkg::RND_W - 1));
  assign stat.out_busy = result_valid && !result_ready;

  // one quotient bit per cycle, only the remainder is kept
  assign rem_shift = {rem, dvd[fsa_pkg::RND_W-1]};
  assign rem_sub   = rem_shift - {1'b0, frame_slots};

  assign mul_op = sync_ok ? rem : slots_left;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address      <= '0;
      rx_turnaround    <= fsa_pkg::RX_TURN_RESET;
      tx_turnaround    <= fsa_pkg::TX_TURN_RESET;
      phy_header_ticks <= fsa_pkg::PHY_HDR_RESET;
      unsync_limit     <= fsa_pkg::UNSYNC_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fsa_pkg::CFG_OWN_ADDRESS:  own_address      <= cfg_data;
        fsa_pkg::CFG_RX_TURN:      rx_turnaround    <= cfg_data[fsa_pkg::TURN_W-1:0];
        fsa_pkg::CFG_TX_TURN:      tx_turnaround    <= cfg_data[fsa_pkg::TURN_W-1:0];
        fsa_pkg::CFG_PHY_HEADER:   phy_header_ticks <= cfg_data[fsa_pkg::TURN_W-1:0];
        fsa_pkg::CFG_UNSYNC_LIMIT: unsync_limit     <= cfg_data[fsa_pkg::SLOT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ev_mode  <= mode;
      ev_crc   <= crc_ok;
      ev_proto <= is_protocol_frame;
      ev_kind  <= packet_kind;
      ev_slots <= slots_in_frame;
      ev_chan  <= beacon_channel;
      ev_ack   <= ack_status_success;
      ev_dest  <= destination;
      dvd      <= random_value;
      rem      <= '0;
      div_cnt  <= '0;
    end else if (cmd.div_step) begin
      dvd     <= {dvd[fsa_pkg::RND_W-2:0], 1'b0};
      rem     <= rem_sub[fsa_pkg::SLOT_W] ? rem_shift[fsa_pkg::SLOT_W-1:0]
                                          : rem_sub[fsa_pkg::SLOT_W-1:0];
      div_cnt <= div_cnt + 1'b1;
    end
    if (cmd.mul_load) begin
      prod <= fsa_pkg::PROD_W'(mul_op) * fsa_pkg::PROD_W'(fsa_pkg::SLOT_TICKS);
    end
  end

  always_comb begin
    beacon_seen_next     = beacon_seen;
    frame_slots_next     = frame_slots;
    picked_slot_next     = picked_slot;
    slots_left_next      = slots_left;
    sync_budget_next     = sync_budget;
    in_sync_next         = in_sync;
    success_flag_next    = success_flag;
    current_channel_next = current_channel;
    cmd_r                = fsa_pkg::RADIO_NONE;
    tstart_r             = 1'b0;
    dly_raw              = '0;
    target_r             = fsa_pkg::MODE_BEACON_LISTEN;
    rreq_r               = 1'b0;
    budget_dec           = (sync_budget != '0) ? sync_budget - 1'b1 : '0;
    unique case (ev_mode)
      fsa_pkg::MODE_BEACON_LISTEN: begin
        beacon_seen_next  = 1'b0;
        success_flag_next = 1'b0;
        cmd_r             = fsa_pkg::RADIO_RX;
        tstart_r          = 1'b1;
        dly_raw           = DW'(fsa_pkg::BEACON_TICKS << fsa_pkg::BEACON_WAIT_SHIFT);
        target_r          = fsa_pkg::MODE_BEACON_WIN;
      end
      fsa_pkg::MODE_FRAME_START: begin
        tstart_r = 1'b1;
        dly_raw  = DW'(fsa_pkg::BEACON_TICKS) - DW'(phy_header_ticks) - DW'(rx_turnaround)
                   - DW'(fsa_pkg::BEACON_RX_MARGIN);
        target_r = fsa_pkg::MODE_BEACON_WIN;
      end
      fsa_pkg::MODE_BEACON_END: begin
        if (ev_crc && ev_proto && (ev_kind == fsa_pkg::KIND_BEACON)) begin
          beacon_seen_next     = 1'b1;
          frame_slots_next     = ev_slots;
          current_channel_next = ev_chan;
        end
      end
      fsa_pkg::MODE_BEACON_WIN: begin
        cmd_r = fsa_pkg::RADIO_STBY;
        if (sync_ok) begin
          in_sync_next     = 1'b1;
          sync_budget_next = unsync_limit;
          picked_slot_next = rem;
          slots_left_next  = frame_slots - rem - 1'b1;
          tstart_r         = 1'b1;
          dly_raw          = DW'(fsa_pkg::LONG_GAP_TICKS) - DW'(tx_turnaround)
                             - DW'(fsa_pkg::DATA_PREP) + DW'(prod) + DW'(1);
          target_r         = fsa_pkg::MODE_DATA_START;
        end else begin
          in_sync_next     = 1'b0;
          sync_budget_next = budget_dec;
          if (budget_dec == '0) begin
            rreq_r = 1'b1;
          end else begin
            tstart_r = 1'b1;
          end
        end
      end
      fsa_pkg::MODE_DATA_START: begin
        cmd_r    = fsa_pkg::RADIO_TX;
        tstart_r = 1'b1;
        dly_raw  = DW'(fsa_pkg::DATA_TICKS - fsa_pkg::DATA_PREP);
        target_r = fsa_pkg::MODE_DATA_END;
      end
      fsa_pkg::MODE_DATA_END: begin
        cmd_r    = fsa_pkg::RADIO_STBY;
        tstart_r = 1'b1;
        dly_raw  = DW'(fsa_pkg::SHORT_GAP_TICKS) - DW'(rx_turnaround)
                   - DW'(fsa_pkg::DATA_PROC);
        target_r = fsa_pkg::MODE_ACK_LISTEN;
      end
      fsa_pkg::MODE_ACK_LISTEN: begin
        cmd_r    = fsa_pkg::RADIO_RX;
        tstart_r = 1'b1;
        dly_raw  = DW'(fsa_pkg::ACK_TICKS - fsa_pkg::ACK_PREP);
        target_r = fsa_pkg::MODE_ACK_WIN;
      end
      fsa_pkg::MODE_ACK_END: begin
        if (ev_crc) begin
          if (ev_proto && (ev_kind == fsa_pkg::KIND_ACK)) begin
            success_flag_next = ev_ack && (ev_dest == own_address);
          end
        end else begin
          in_sync_next = 1'b0;
        end
      end
      fsa_pkg::MODE_ACK_WIN: begin
        cmd_r    = fsa_pkg::RADIO_STBY;
        tstart_r = 1'b1;
        dly_raw  = DW'(fsa_pkg::SHORT_GAP_TICKS) - DW'(rx_turnaround)
                   - DW'(fsa_pkg::ACK_PROC) + DW'(prod);
        target_r = fsa_pkg::MODE_BEACON_LISTEN;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beacon_seen     <= 1'b0;
      frame_slots     <= '0;
      picked_slot     <= '0;
      slots_left      <= '0;
      sync_budget     <= fsa_pkg::UNSYNC_RESET;
      in_sync         <= 1'b0;
      success_flag    <= 1'b0;
      current_channel <= fsa_pkg::DEFAULT_CHANNEL;
    end else if (cmd.finish) begin
      beacon_seen     <= beacon_seen_next;
      frame_slots     <= frame_slots_next;
      picked_slot     <= picked_slot_next;
      slots_left      <= slots_left_next;
      sync_budget     <= sync_budget_next;
      in_sync         <= in_sync_next;
      success_flag    <= success_flag_next;
      current_channel <= current_channel_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.finish) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      radio_cmd     <= cmd_r;
      timer_start   <= tstart_r;
      delay_ticks   <= fsa_pkg::clamp_delay(dly_raw);
      timer_target  <= target_r;
      synchronized  <= in_sync_next;
      reset_request <= rreq_r;
      chosen_slot   <= picked_slot_next;
      ack_success   <= success_flag_next;
      channel       <= current_channel_next;
    end
  end

endmodule

[sv/fsa_node_slot_sequencer_top.sv]
// one event is in work at a time: a new event beat is taken only once the last one has finished
// when the slot is drawn, the modulo takes 16 steps, one quotient bit each
// the 16-by-8 remainder unit runs between decode and the slot multiply, before finish
// a finished result waits in the output register while the next event beat is taken
// reset (rst, synchronous, active high): config to defaults, budget to 16, channel 26, unsynced
// config writes are always ready and take effect at once
module fsa_node_slot_sequencer_top (
  input  logic                            clk,
  input  logic                            rst,
  // config write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fsa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fsa_pkg::CFG_DATA_W-1:0]  cfg_data,
  // event channel
  input  logic                            item_valid,
  output logic                            item_ready,
  input  logic [fsa_pkg::MODE_W-1:0]      mode,
  input  logic                            crc_ok,
  input  logic                            is_protocol_frame,
  input  logic [fsa_pkg::KIND_W-1:0]      packet_kind,
  input  logic [fsa_pkg::SLOT_W-1:0]      slots_in_frame,
  input  logic [fsa_pkg::CHAN_W-1:0]      beacon_channel,
  input  logic                            ack_status_success,
  input  logic [fsa_pkg::ADDR_W-1:0]      destination,
  input  logic [fsa_pkg::RND_W-1:0]       random_value,
  // result channel
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic [fsa_pkg::CMD_W-1:0]       radio_cmd,
  output logic                            timer_start,
  output logic [fsa_pkg::TICK_W-1:0]      delay_ticks,
  output logic [fsa_pkg::MODE_W-1:0]      timer_target,
  output logic                            synchronized,
  output logic                            reset_request,
  output logic [fsa_pkg::SLOT_W-1:0]      chosen_slot,
  output logic                            ack_success,
  output logic [fsa_pkg::CHAN_W-1:0]      channel
);

  fsa_pkg::dp_cmd_t  cmd;
  fsa_pkg::dp_stat_t stat;

  // registers are plain flops, so a write beat never stalls
  assign cfg_ready = 1'b1;

  // controller: idle, decode, modulo steps, slot multiply, finish
  fsa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // datapath: holds all mac state and the result register
  fsa_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .mode               (mode),
    .crc_ok             (crc_ok),
    .is_protocol_frame  (is_protocol_frame),
    .packet_kind        (packet_kind),
    .slots_in_frame     (slots_in_frame),
    .beacon_channel     (beacon_channel),
    .ack_status_success (ack_status_success),
    .destination        (destination),
    .random_value       (random_value),
    .result_valid       (result_valid),
    .result_ready       (result_ready),
    .radio_cmd          (radio_cmd),
    .timer_start        (timer_start),
    .delay_ticks        (delay_ticks),
    .timer_target       (timer_target),
    .synchronized       (synchronized),
    .reset_request      (reset_request),
    .chosen_slot        (chosen_slot),
    .ack_success        (ack_success),
    .channel            (channel)
  );

`ifndef ASSERT_OFF
  // one event at a time: after an event beat the input side is busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("event accepted while previous event still in work");

  // a reset request comes only from a missed beacon, which drops sync and starts no timer
  a_reset_req_unsynced: assert property (@(posedge clk) disable iff (rst)
    result_valid && reset_request |-> !synchronized && !timer_start)
    else $error("reset request with sync or timer set");

  // no timer means zero delay and zero target
  a_no_timer_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !timer_start |-> delay_ticks == '0 && timer_target == '0)
    else $error("timer fields set without timer start");

  // a new result is never written over one still waiting
  a_result_not_lost: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(delay_ticks))
    else $error("pending result dropped or changed");
`endif

endmodule
